@@ sv/pjlm_pkg.sv @@
// ----------------------------------------------------------------------------
// pjlm_pkg
// Shared widths, constants and types of the period jitter and load monitor.
// ----------------------------------------------------------------------------
package pjlm_pkg;

    localparam int unsigned TIME_BITS = 32;
    localparam int unsigned BUSY_W    = 20;
    localparam int unsigned NOM_W     = 24;
    localparam int unsigned CNT_W     = 10;
    localparam int unsigned PSUM_W    = 42;
    localparam int unsigned BSUM_W    = 30;
    localparam int unsigned LDIV_W    = 37;
    localparam int unsigned LOAD_W    = 7;

    localparam logic [CNT_W-1:0]  MAX_WINDOW    = 10'd1023;
    localparam logic [CNT_W-1:0]  SAMPLES_RESET = 10'd200;
    localparam logic [NOM_W-1:0]  NOMINAL_RESET = 24'd10000;
    localparam logic [LOAD_W-1:0] LOAD_MAX      = 7'd100;

    // configuration register indexes
    localparam logic CFG_NOMINAL = 1'b0;
    localparam logic CFG_SAMPLES = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_ACCUM,
        S_CHECK,
        S_DIV,
        S_REPORT
    } t_state;

endpackage

@@ sv/pjlm_in_if.sv @@
// ----------------------------------------------------------------------------
// pjlm_in_if
// Interrupt event channel: timestamp and busy time of one period.
// ----------------------------------------------------------------------------
interface pjlm_in_if;
    import pjlm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] event_time_us;
    logic [BUSY_W-1:0]    busy_us;

    modport source (output valid, output event_time_us, output busy_us, input ready);
    modport sink   (input valid, input event_time_us, input busy_us, output ready);
endinterface

@@ sv/pjlm_out_if.sv @@
// ----------------------------------------------------------------------------
// pjlm_out_if
// Report channel: window statistics of the monitored interrupt.
// ----------------------------------------------------------------------------
interface pjlm_out_if;
    import pjlm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] mean_period_us;
    logic [TIME_BITS-1:0] longest_period_us;
    logic [TIME_BITS-1:0] shortest_period_us;
    logic [TIME_BITS-1:0] deviation_us;
    logic [LOAD_W-1:0]    load_pct;
    logic [CNT_W-1:0]     window_samples;

    modport source (
        output valid, output mean_period_us, output longest_period_us,
        output shortest_period_us, output deviation_us, output load_pct,
        output window_samples, input ready
    );
    modport sink (
        input valid, input mean_period_us, input longest_period_us,
        input shortest_period_us, input deviation_us, input load_pct,
        input window_samples, output ready
    );
endinterface

@@ sv/pjlm_sdiv.sv @@
// ----------------------------------------------------------------------------
// pjlm_sdiv
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pjlm_sdiv #(
    parameter int unsigned N_W = 42,
    parameter int unsigned D_W = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quotient
);
    localparam int unsigned CW = $clog2(N_W + 1);

    logic [N_W-1:0] r_acc;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_div;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [D_W:0]   w_trial;
    logic [D_W:0]   w_diff;
    logic           w_ge;

    // dividend shifts out at the top, quotient bits shift in at the bottom
    assign w_trial = {r_rem, r_acc[N_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[N_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_acc;
endmodule

@@ sv/period_jitter_load_monitor.sv @@
// ----------------------------------------------------------------------------
// period_jitter_load_monitor
// Flow: an item passes S_DIFF, S_ACCUM and S_CHECK; one that closes a window
// then waits in S_DIV for the serial divisions of the period sum and busy sum
// and reports from S_REPORT, which stalls while a report is held. The first
// item after reset leaves S_DIFF for S_IDLE; new items are taken in S_IDLE only.
// Reset: synchronous active low; registers go to 10000 us nominal and 200
// samples, statistics clear and the first item only sets the reference.
// ----------------------------------------------------------------------------
module period_jitter_load_monitor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pjlm_in_if.sink                     i_event,
    pjlm_out_if.source                  o_report,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [pjlm_pkg::NOM_W-1:0]  i_cfg_data
);
    import pjlm_pkg::*;

    t_state r_state, n_state;

    logic [NOM_W-1:0]     r_nominal;
    logic [CNT_W-1:0]     r_samples;

    logic [TIME_BITS-1:0] r_now;
    logic [BUSY_W-1:0]    r_busy;
    logic                 r_have_ref;
    logic [TIME_BITS-1:0] r_prev;
    logic [TIME_BITS-1:0] r_period;
    logic [PSUM_W-1:0]    r_period_sum;
    logic [BSUM_W-1:0]    r_busy_sum;
    logic [TIME_BITS-1:0] r_longest;
    logic [TIME_BITS-1:0] r_shortest;
    logic [CNT_W-1:0]     r_count;
    logic [TIME_BITS-1:0] r_jitter;

    logic                 r_out_valid;
    logic [TIME_BITS-1:0] r_out_mean;
    logic [TIME_BITS-1:0] r_out_longest;
    logic [TIME_BITS-1:0] r_out_shortest;
    logic [TIME_BITS-1:0] r_out_jitter;
    logic [LOAD_W-1:0]    r_out_load;
    logic [CNT_W-1:0]     r_out_samples;

    logic                 w_in_ready;
    logic                 w_accept;
    logic                 w_div_start;
    logic                 w_out_load;
    logic [CNT_W-1:0]     w_wlen;
    logic                 w_window_full;
    logic [TIME_BITS-1:0] w_nom_ext;
    logic [TIME_BITS-1:0] w_hi_dev;
    logic [TIME_BITS-1:0] w_lo_dev;
    logic [LDIV_W-1:0]    w_busy100;
    logic                 w_mean_done;
    logic                 w_load_done;
    logic [PSUM_W-1:0]    w_mean_q;
    logic [LDIV_W-1:0]    w_load_q;
    logic [LOAD_W-1:0]    w_load;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal <= NOMINAL_RESET;
            r_samples <= SAMPLES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NOMINAL: r_nominal <= i_cfg_data;
                CFG_SAMPLES: r_samples <= i_cfg_data[CNT_W-1:0];
                default:     r_nominal <= r_nominal;
            endcase
        end
    end

    // zero acts as one, large values clamp to the window limit
    always_comb begin
        if (r_samples == '0) begin
            w_wlen = CNT_W'(1);
        end else if (r_samples > MAX_WINDOW) begin
            w_wlen = MAX_WINDOW;
        end else begin
            w_wlen = r_samples;
        end
    end

    assign w_window_full = r_count >= w_wlen;

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_event.valid) n_state = S_DIFF;
            S_DIFF:   n_state = r_have_ref ? S_ACCUM : S_IDLE;
            S_ACCUM:  n_state = S_CHECK;
            S_CHECK:  n_state = w_window_full ? S_DIV : S_IDLE;
            S_DIV:    if (w_mean_done && w_load_done) n_state = S_REPORT;
            S_REPORT: if (!r_out_valid || o_report.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            S_IDLE:   w_in_ready  = 1'b1;
            S_CHECK:  w_div_start = w_window_full;
            S_REPORT: w_out_load  = !r_out_valid || o_report.ready;
            default:  w_in_ready  = 1'b0;
        endcase
    end

    assign w_accept      = i_event.valid && w_in_ready;
    assign i_event.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now  <= i_event.event_time_us;
            r_busy <= i_event.busy_us;
        end
        if (r_state == S_DIFF) begin
            r_period <= r_now - r_prev;
        end
        if (r_state == S_CHECK) begin
            r_jitter <= (w_hi_dev > w_lo_dev) ? w_hi_dev : w_lo_dev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_ref   <= 1'b0;
            r_prev       <= '0;
            r_period_sum <= '0;
            r_busy_sum   <= '0;
            r_longest    <= '0;
            r_shortest   <= '1;
            r_count      <= '0;
        end else begin
            if (r_state == S_DIFF) begin
                r_have_ref <= 1'b1;
                r_prev     <= r_now;
            end
            if (r_state == S_ACCUM) begin
                r_period_sum <= r_period_sum + {{(PSUM_W-TIME_BITS){1'b0}}, r_period};
                r_busy_sum   <= r_busy_sum + {{(BSUM_W-BUSY_W){1'b0}}, r_busy};
                r_count      <= r_count + 1'b1;
                if (r_period > r_longest) begin
                    r_longest <= r_period;
                end
                if (r_period < r_shortest) begin
                    r_shortest <= r_period;
                end
            end
            if (w_out_load) begin
                r_period_sum <= '0;
                r_busy_sum   <= '0;
                r_longest    <= '0;
                r_shortest   <= '1;
                r_count      <= '0;
            end
        end
    end

    assign w_nom_ext = {{(TIME_BITS-NOM_W){1'b0}}, r_nominal};
    assign w_hi_dev  = (r_longest > w_nom_ext) ? r_longest - w_nom_ext : '0;
    assign w_lo_dev  = (r_shortest < w_nom_ext) ? w_nom_ext - r_shortest : '0;

    // busy sum times 100 as 64 + 32 + 4
    assign w_busy100 = {1'b0, r_busy_sum, 6'b0}
                     + {2'b0, r_busy_sum, 5'b0}
                     + {5'b0, r_busy_sum, 2'b0};

    pjlm_sdiv #(
        .N_W (PSUM_W),
        .D_W (CNT_W)
    ) u_mean_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_period_sum),
        .i_divisor  (r_count),
        .o_done     (w_mean_done),
        .o_quotient (w_mean_q)
    );

    pjlm_sdiv #(
        .N_W (LDIV_W),
        .D_W (PSUM_W)
    ) u_load_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_busy100),
        .i_divisor  (r_period_sum),
        .o_done     (w_load_done),
        .o_quotient (w_load_q)
    );

    always_comb begin
        if (r_period_sum == '0) begin
            w_load = '0;
        end else if ((|w_load_q[LDIV_W-1:LOAD_W]) || (w_load_q[LOAD_W-1:0] > LOAD_MAX)) begin
            w_load = LOAD_MAX;
        end else begin
            w_load = w_load_q[LOAD_W-1:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_report.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_mean     <= w_mean_q[TIME_BITS-1:0];
            r_out_longest  <= r_longest;
            r_out_shortest <= r_shortest;
            r_out_jitter   <= r_jitter;
            r_out_load     <= w_load;
            r_out_samples  <= r_count;
        end
    end

    assign o_report.valid              = r_out_valid;
    assign o_report.mean_period_us     = r_out_mean;
    assign o_report.longest_period_us  = r_out_longest;
    assign o_report.shortest_period_us = r_out_shortest;
    assign o_report.deviation_us       = r_out_jitter;
    assign o_report.load_pct           = r_out_load;
    assign o_report.window_samples     = r_out_samples;

    // ---------------- assertions ----------------
    a_report_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (w_mean_done && w_load_done))
        else $error("report loaded before both divisions finished");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_WINDOW)
        else $error("period count beyond window limit");

    a_min_max_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_shortest <= r_longest))
        else $error("shortest period above longest period");

    a_window_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_count == '0 && r_period_sum == '0))
        else $error("statistics not cleared after report");
endmodule
